// File: sv/rpn_stack_evaluator_top_macros.svh
// ----------------------------------------------------------------------------
// rpn stack evaluator assertion macros
// shared property shapes for the port checker, clocked on aclk
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_EVALUATOR_TOP_MACROS_SVH
`define RPN_STACK_EVALUATOR_TOP_MACROS_SVH

// same-cycle implication, off while in reset
`define RPN_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define RPN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// holds in the cycle after a reset cycle
`define RPN_ASSERT_AFTER_RESET(label, cons, msg) \
    label: assert property (@(posedge aclk) !aresetn |=> (cons)) \
        else $error(msg);

`endif

// File: sv/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// shared types, codes and defaults of the rpn stack evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

    localparam int DEF_STACK_DEPTH   = 16;
    localparam int DEF_FRACTION_BITS = 16;

    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 3;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;

    // token codes
    localparam cmd_t CMD_PUSH    = 3'd0;
    localparam cmd_t CMD_ADD     = 3'd1;
    localparam cmd_t CMD_SUB     = 3'd2;
    localparam cmd_t CMD_MUL     = 3'd3;
    localparam cmd_t CMD_DIV     = 3'd4;
    localparam cmd_t CMD_END     = 3'd5;
    localparam cmd_t CMD_INVALID = 3'd6;

    // status codes
    localparam status_t ST_OK      = 3'd0;
    localparam status_t ST_DIV0    = 3'd1;
    localparam status_t ST_INVALID = 3'd2;
    localparam status_t ST_UNDER   = 3'd3;
    localparam status_t ST_FULL    = 3'd4;
    localparam status_t ST_SAT     = 3'd5;

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic              sat;
        logic [DATA_W-1:0] value;
    } div_res_t;

endpackage

`default_nettype wire

// File: sv/rpn_stack_mem.sv
// ----------------------------------------------------------------------------
// rpn_stack_mem
// operand stack storage, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_stack_mem #(
    parameter int DEPTH  = rpn_pkg::DEF_STACK_DEPTH,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                      aclk,
    input  wire logic                      wr_en,
    input  wire logic [ADDR_W-1:0]         wr_addr,
    input  wire logic [rpn_pkg::DATA_W-1:0] wr_data,
    input  wire logic [ADDR_W-1:0]         rd_addr,
    output logic      [rpn_pkg::DATA_W-1:0] rd_data
);
    import rpn_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: sv/rpn_div.sv
// ----------------------------------------------------------------------------
// rpn_div
// iterative fixed-point divider, one quotient bit per cycle, saturating
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_div #(
    parameter int FRACTION_BITS = rpn_pkg::DEF_FRACTION_BITS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire rpn_pkg::div_req_t div_req,
    output rpn_pkg::div_res_t      div_res
);
    import rpn_pkg::*;

    localparam int A_W   = DATA_W + FRACTION_BITS;
    localparam int CNT_W = $clog2(DATA_W + 1);

    typedef enum logic [1:0] {
        D_IDLE,
        D_CHECK,
        D_ITER,
        D_FIN
    } dstate_t;

    dstate_t           state_reg;
    logic [A_W-1:0]    a_reg;
    logic [DATA_W-1:0] b_reg;
    logic              neg_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] q_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic              sat_reg;
    logic [DATA_W-1:0] value_reg;

    logic [DATA_W-1:0] num_mag;
    logic [DATA_W-1:0] den_mag;
    logic [DATA_W-1:0] a_hi;
    logic [DATA_W:0]   trial;

    assign num_mag = div_req.num[DATA_W-1] ? (~div_req.num + 1'b1) : div_req.num;
    assign den_mag = div_req.den[DATA_W-1] ? (~div_req.den + 1'b1) : div_req.den;
    // upper bits of the scaled dividend; quotient fits 32 bits when these are below b
    assign a_hi    = {{(DATA_W-FRACTION_BITS){1'b0}}, a_reg[A_W-1:DATA_W]};
    assign trial   = {rem_reg, q_reg[DATA_W-1]} - {1'b0, b_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE: begin
                    if (div_req.start) begin
                        a_reg     <= {num_mag, {FRACTION_BITS{1'b0}}};
                        b_reg     <= den_mag;
                        neg_reg   <= div_req.num[DATA_W-1] ^ div_req.den[DATA_W-1];
                        state_reg <= D_CHECK;
                    end
                end
                D_CHECK: begin
                    if (a_hi >= b_reg) begin
                        sat_reg   <= 1'b1;
                        value_reg <= neg_reg ? SAT_MIN : SAT_MAX;
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end else begin
                        rem_reg   <= a_hi;
                        q_reg     <= a_reg[DATA_W-1:0];
                        cnt_reg   <= CNT_W'(DATA_W);
                        state_reg <= D_ITER;
                    end
                end
                D_ITER: begin
                    // dividend bits shift out of q_reg as quotient bits shift in
                    if (!trial[DATA_W]) begin
                        rem_reg <= trial[DATA_W-1:0];
                        q_reg   <= {q_reg[DATA_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= {rem_reg[DATA_W-2:0], q_reg[DATA_W-1]};
                        q_reg   <= {q_reg[DATA_W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1)) begin
                        state_reg <= D_FIN;
                    end
                end
                D_FIN: begin
                    if (!neg_reg) begin
                        sat_reg   <= q_reg[DATA_W-1];
                        value_reg <= q_reg[DATA_W-1] ? SAT_MAX : q_reg;
                    end else if (q_reg > SAT_MIN) begin
                        sat_reg   <= 1'b1;
                        value_reg <= SAT_MIN;
                    end else begin
                        sat_reg   <= 1'b0;
                        value_reg <= ~q_reg + 1'b1;
                    end
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default: begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign div_res.done  = done_reg;
    assign div_res.sat   = sat_reg;
    assign div_res.value = value_reg;

endmodule

`default_nettype wire

// File: sv/rpn_stack_evaluator_top.sv
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_top
// reverse polish evaluator over a bounded Q16.16 operand stack
// ----------------------------------------------------------------------------
// One token is taken at a time and gives exactly one result item. The operands
// live in a stack memory with one registered read port, so an operator fetches
// the top entry and then the second entry before it computes. Multiply goes
// through one registered 32x32 product; divide by a nonzero value waits on the
// one-bit-per-cycle divider, which stops early when the quotient does not fit.
// A new token is taken while the previous result still waits on m_ready.
`default_nettype none

module rpn_stack_evaluator_top #(
    parameter int STACK_DEPTH   = rpn_pkg::DEF_STACK_DEPTH,
    parameter int FRACTION_BITS = rpn_pkg::DEF_FRACTION_BITS,
    parameter int LEVEL_W       = $clog2(STACK_DEPTH + 1)
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire rpn_pkg::cmd_t                  s_cmd,
    input  wire logic signed [rpn_pkg::DATA_W-1:0] s_operand_value,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output rpn_pkg::status_t                    m_status,
    output logic                                m_result_valid,
    output logic signed [rpn_pkg::DATA_W-1:0]   m_result_value,
    output logic        [LEVEL_W-1:0]           m_stack_level
);
    import rpn_pkg::*;

    localparam int ADDR_W = $clog2(STACK_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_T,
        S_RD_S,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_POP,
        S_RESP
    } state_t;

    state_t              state_reg, state_next;
    logic [LEVEL_W-1:0]  sp_reg, sp_next;
    cmd_t                cmd_reg, cmd_next;
    logic [DATA_W-1:0]   t_reg, t_next;
    logic signed [2*DATA_W-1:0] prod_reg, prod_next;
    status_t             pend_status_reg, pend_status_next;
    logic                pend_rvalid_reg, pend_rvalid_next;
    logic [DATA_W-1:0]   pend_value_reg, pend_value_next;
    logic                m_valid_reg, m_valid_next;
    status_t             m_status_reg, m_status_next;
    logic                m_rvalid_reg, m_rvalid_next;
    logic [DATA_W-1:0]   m_value_reg, m_value_next;
    logic [LEVEL_W-1:0]  m_level_reg, m_level_next;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [DATA_W-1:0]   mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [DATA_W-1:0]   mem_rdata;

    div_req_t            div_req;
    div_res_t            div_res;

    logic [LEVEL_W-1:0]  sp_m1, sp_m2;
    logic                accept, out_free, stack_full;
    logic [DATA_W:0]     sum;
    logic                sum_sat;
    logic [DATA_W-1:0]   sum_val;
    logic signed [2*DATA_W-1:0] prod_shift;
    logic                mul_sat;
    logic [DATA_W-1:0]   mul_val;

    rpn_stack_mem #(
        .DEPTH  (STACK_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    rpn_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .div_req (div_req),
        .div_res (div_res)
    );

    assign sp_m1      = sp_reg - 1'b1;
    assign sp_m2      = sp_reg - LEVEL_W'(2);
    assign s_ready    = (state_reg == S_IDLE);
    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign stack_full = (sp_reg == LEVEL_W'(STACK_DEPTH));

    // an entry is never read in the same cycle as its write
    assign mem_raddr = (state_reg == S_RD_T) ? sp_m1[ADDR_W-1:0] : sp_m2[ADDR_W-1:0];

    // in S_EXEC the read data holds the second entry, t_reg the top
    assign sum = (cmd_reg == CMD_SUB)
               ? ({mem_rdata[DATA_W-1], mem_rdata} - {t_reg[DATA_W-1], t_reg})
               : ({mem_rdata[DATA_W-1], mem_rdata} + {t_reg[DATA_W-1], t_reg});
    assign sum_sat = sum[DATA_W] ^ sum[DATA_W-1];
    assign sum_val = sum_sat ? (sum[DATA_W] ? SAT_MIN : SAT_MAX) : sum[DATA_W-1:0];

    // arithmetic shift gives the floor of the scaled product
    assign prod_shift = prod_reg >>> FRACTION_BITS;
    assign mul_sat    = !((&prod_shift[2*DATA_W-1:DATA_W-1]) ||
                          !(|prod_shift[2*DATA_W-1:DATA_W-1]));
    assign mul_val    = mul_sat ? (prod_shift[2*DATA_W-1] ? SAT_MIN : SAT_MAX)
                                : prod_shift[DATA_W-1:0];

    always_comb begin
        state_next       = state_reg;
        sp_next          = sp_reg;
        cmd_next         = cmd_reg;
        t_next           = t_reg;
        prod_next        = prod_reg;
        pend_status_next = pend_status_reg;
        pend_rvalid_next = pend_rvalid_reg;
        pend_value_next  = pend_value_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        m_rvalid_next    = m_rvalid_reg;
        m_value_next     = m_value_reg;
        m_level_next     = m_level_reg;
        mem_we           = 1'b0;
        mem_waddr        = sp_m2[ADDR_W-1:0];
        mem_wdata        = s_operand_value;
        div_req.start    = 1'b0;
        div_req.num      = mem_rdata;
        div_req.den      = t_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd_next         = s_cmd;
                    pend_status_next = ST_OK;
                    pend_rvalid_next = 1'b0;
                    pend_value_next  = '0;
                    state_next       = S_RESP;
                    case (s_cmd)
                        CMD_PUSH: begin
                            if (stack_full) begin
                                pend_status_next = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = sp_reg[ADDR_W-1:0];
                                sp_next   = sp_reg + 1'b1;
                            end
                        end
                        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                            if (sp_reg < LEVEL_W'(2)) begin
                                pend_status_next = ST_UNDER;
                            end else begin
                                state_next = S_RD_T;
                            end
                        end
                        CMD_END: begin
                            if (sp_reg == '0) begin
                                pend_status_next = ST_UNDER;
                            end else begin
                                state_next = S_RD_T;
                            end
                        end
                        default: begin
                            sp_next          = '0;
                            pend_status_next = ST_INVALID;
                        end
                    endcase
                end
            end
            S_RD_T: begin
                state_next = (cmd_reg == CMD_END) ? S_POP : S_RD_S;
            end
            S_POP: begin
                pend_rvalid_next = 1'b1;
                pend_value_next  = mem_rdata;
                sp_next          = sp_m1;
                state_next       = S_RESP;
            end
            S_RD_S: begin
                t_next     = mem_rdata;
                state_next = S_EXEC;
            end
            S_EXEC: begin
                case (cmd_reg)
                    CMD_ADD, CMD_SUB: begin
                        mem_we           = 1'b1;
                        mem_wdata        = sum_val;
                        sp_next          = sp_m1;
                        pend_status_next = sum_sat ? ST_SAT : ST_OK;
                        state_next       = S_RESP;
                    end
                    CMD_MUL: begin
                        prod_next  = $signed(mem_rdata) * $signed(t_reg);
                        state_next = S_MUL;
                    end
                    CMD_DIV: begin
                        if (t_reg == '0) begin
                            sp_next          = sp_m2;
                            pend_status_next = ST_DIV0;
                            state_next       = S_RESP;
                        end else begin
                            div_req.start = 1'b1;
                            state_next    = S_DIV;
                        end
                    end
                    default: begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_MUL: begin
                mem_we           = 1'b1;
                mem_wdata        = mul_val;
                sp_next          = sp_m1;
                pend_status_next = mul_sat ? ST_SAT : ST_OK;
                state_next       = S_RESP;
            end
            S_DIV: begin
                if (div_res.done) begin
                    mem_we           = 1'b1;
                    mem_wdata        = div_res.value;
                    sp_next          = sp_m1;
                    pend_status_next = div_res.sat ? ST_SAT : ST_OK;
                    state_next       = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = pend_status_reg;
                    m_rvalid_next = pend_rvalid_reg;
                    m_value_next  = pend_value_reg;
                    m_level_next  = sp_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            sp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sp_reg      <= sp_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg         <= cmd_next;
        t_reg           <= t_next;
        prod_reg        <= prod_next;
        pend_status_reg <= pend_status_next;
        pend_rvalid_reg <= pend_rvalid_next;
        pend_value_reg  <= pend_value_next;
        m_status_reg    <= m_status_next;
        m_rvalid_reg    <= m_rvalid_next;
        m_value_reg     <= m_value_next;
        m_level_reg     <= m_level_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_result_valid = m_rvalid_reg;
    assign m_result_value = m_value_reg;
    assign m_stack_level  = m_level_reg;

endmodule

`default_nettype wire

// File: sv/rpn_checker.sv
// ----------------------------------------------------------------------------
// rpn_checker
// port-level checks of the rpn stack evaluator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "rpn_stack_evaluator_top_macros.svh"

module rpn_checker #(
    parameter int STACK_DEPTH = rpn_pkg::DEF_STACK_DEPTH,
    parameter int LEVEL_W     = $clog2(STACK_DEPTH + 1)
) (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire rpn_pkg::status_t             m_status,
    input wire logic                         m_result_valid,
    input wire logic [rpn_pkg::DATA_W-1:0]   m_result_value,
    input wire logic [LEVEL_W-1:0]           m_stack_level
);
    import rpn_pkg::*;

    `RPN_ASSERT_AFTER_RESET(a_reset_no_item, !m_valid, "result item present after reset")

    `RPN_ASSERT_SAME(a_result_ok, m_valid && m_result_valid, m_status == ST_OK, "final result with bad status")

    `RPN_ASSERT_SAME(a_invalid_empty, m_valid && m_status == ST_INVALID, m_stack_level == '0, "invalid token left entries")

    `RPN_ASSERT_SAME(a_full_level, m_valid && m_status == ST_FULL, m_stack_level == LEVEL_W'(STACK_DEPTH), "stack full reported below depth")

    `RPN_ASSERT_NEXT(a_stall_hold, m_valid && !m_ready, m_valid && $stable(m_result_value) && $stable(m_status), "stalled result item changed")

endmodule

bind rpn_stack_evaluator_top rpn_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_rpn_checker (.*);

`default_nettype wire
